@@ rtl/dmpd_pkg.sv @@
// Package for the dual motor position drive.
// Holds the operation codes, register indexes, reset values and shared structs.
// No dependencies.
`default_nettype none

package dmpd_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 2;
  localparam int POS_W   = 8;
  localparam int DRV_W   = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_SET_TARGET = 2'd0,
    OP_SAMPLE     = 2'd1,
    OP_TICK       = 2'd2,
    OP_POLL       = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_BAND           = 3'd0,
    REG_PROP_BAND           = 3'd1,
    REG_FULL_DRIVE          = 3'd2,
    REG_WING_OFFSET_FORWARD = 3'd3,
    REG_WING_OFFSET_REVERSE = 3'd4,
    REG_NECK_OFFSET_FORWARD = 3'd5,
    REG_NECK_OFFSET_REVERSE = 3'd6
  } reg_idx_t;

  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  localparam logic [DRV_W-1:0] RST_STOP_BAND           = 8'd2;
  localparam logic [DRV_W-1:0] RST_PROP_BAND           = 8'd50;
  localparam logic [DRV_W-1:0] RST_FULL_DRIVE          = 8'd255;
  localparam logic [DRV_W-1:0] RST_WING_OFFSET_FORWARD = 8'd40;
  localparam logic [DRV_W-1:0] RST_WING_OFFSET_REVERSE = 8'd70;
  localparam logic [DRV_W-1:0] RST_NECK_OFFSET_FORWARD = 8'd30;
  localparam logic [DRV_W-1:0] RST_NECK_OFFSET_REVERSE = 8'd40;

  localparam logic [DRV_W-1:0] DRIVE_MAX = 8'd255;

  typedef struct packed {
    logic [DRV_W-1:0] stop_band;
    logic [DRV_W-1:0] prop_band;
    logic [DRV_W-1:0] full_drive;
    logic [DRV_W-1:0] wing_offset_forward;
    logic [DRV_W-1:0] wing_offset_reverse;
    logic [DRV_W-1:0] neck_offset_forward;
    logic [DRV_W-1:0] neck_offset_reverse;
  } cfg_t;

  typedef struct packed {
    logic             reverse;
    logic [DRV_W-1:0] drive;
    logic             done;
  } motor_out_t;

  // Target positions after reset; channels past the fourth start at zero.
  function automatic logic [POS_W-1:0] reset_target(input int ch);
    logic [POS_W-1:0] t;
    case (ch)
      0:       t = 8'd70;
      1:       t = 8'd165;
      2:       t = 8'd200;
      3:       t = 8'd120;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dmpd_item_if.sv @@
// Input channel of the dual motor position drive: valid/ready and one command.
// Depends on dmpd_pkg.
`default_nettype none

interface dmpd_item_if;
  import dmpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] motor_index;
  logic [POS_W-1:0] value;

  modport source (output valid, operation, motor_index, value, input ready);
  modport sink   (input valid, operation, motor_index, value, output ready);
endinterface

`default_nettype wire

@@ rtl/dmpd_result_if.sv @@
// Result channel of the dual motor position drive: drive results and poll answers.
// Depends on dmpd_pkg.
`default_nettype none

interface dmpd_result_if;
  import dmpd_pkg::*;

  logic             valid;
  logic             ready;
  logic             result_kind;
  logic             wing_reverse;
  logic [DRV_W-1:0] wing_drive;
  logic             wing_done;
  logic             neck_reverse;
  logic [DRV_W-1:0] neck_drive;
  logic             neck_done;
  logic [POS_W-1:0] polled_position;

  modport source (output valid, result_kind, wing_reverse, wing_drive, wing_done,
                  neck_reverse, neck_drive, neck_done, polled_position,
                  input ready);
  modport sink   (input valid, result_kind, wing_reverse, wing_drive, wing_done,
                  neck_reverse, neck_drive, neck_done, polled_position,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/dmpd_cfg_if.sv @@
// Configuration write channel of the dual motor position drive.
// Depends on dmpd_pkg.
`default_nettype none

interface dmpd_cfg_if;
  import dmpd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DRV_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/dmpd_cfg_regs.sv @@
// Configuration register file: seven 8-bit registers written over the config channel.
// Depends on dmpd_pkg and dmpd_cfg_if.
`default_nettype none

module dmpd_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  dmpd_cfg_if.sink            cfg_ch,
  output dmpd_pkg::cfg_t      cfg
);
  import dmpd_pkg::*;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_band           <= RST_STOP_BAND;
      cfg.prop_band           <= RST_PROP_BAND;
      cfg.full_drive          <= RST_FULL_DRIVE;
      cfg.wing_offset_forward <= RST_WING_OFFSET_FORWARD;
      cfg.wing_offset_reverse <= RST_WING_OFFSET_REVERSE;
      cfg.neck_offset_forward <= RST_NECK_OFFSET_FORWARD;
      cfg.neck_offset_reverse <= RST_NECK_OFFSET_REVERSE;
    end else if (cfg_ch.valid) begin
      // An index past the last register is dropped.
      case (reg_idx_t'(cfg_ch.index))
        REG_STOP_BAND:           cfg.stop_band           <= cfg_ch.data;
        REG_PROP_BAND:           cfg.prop_band           <= cfg_ch.data;
        REG_FULL_DRIVE:          cfg.full_drive          <= cfg_ch.data;
        REG_WING_OFFSET_FORWARD: cfg.wing_offset_forward <= cfg_ch.data;
        REG_WING_OFFSET_REVERSE: cfg.wing_offset_reverse <= cfg_ch.data;
        REG_NECK_OFFSET_FORWARD: cfg.neck_offset_forward <= cfg_ch.data;
        REG_NECK_OFFSET_REVERSE: cfg.neck_offset_reverse <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/dmpd_motor_drive.sv @@
// Drive law for one DC motor: direction, deadband stop, proportional and full speed.
// Depends on dmpd_pkg.
`default_nettype none

module dmpd_motor_drive (
  input  wire logic [dmpd_pkg::POS_W-1:0] target,
  input  wire logic [dmpd_pkg::POS_W-1:0] measured,
  input  wire logic                       done_in,
  input  wire logic [dmpd_pkg::DRV_W-1:0] stop_band,
  input  wire logic [dmpd_pkg::DRV_W-1:0] prop_band,
  input  wire logic [dmpd_pkg::DRV_W-1:0] full_drive,
  input  wire logic [dmpd_pkg::DRV_W-1:0] offset_forward,
  input  wire logic [dmpd_pkg::DRV_W-1:0] offset_reverse,
  output dmpd_pkg::motor_out_t            motor
);
  import dmpd_pkg::*;

  logic             reverse;
  logic [POS_W-1:0] gap;
  logic [DRV_W-1:0] offset;
  logic [POS_W+1:0] prop;

  assign reverse = (target < measured);
  assign gap     = reverse ? (measured - target) : (target - measured);
  assign offset  = reverse ? offset_reverse : offset_forward;
  assign prop    = {1'b0, gap, 1'b0} + {2'b00, offset};

  always_comb begin
    motor.reverse = reverse;
    motor.done    = done_in;
    if (done_in) begin
      motor.drive = '0;
    end else if (gap <= stop_band) begin
      motor.drive = '0;
      motor.done  = 1'b1;
    end else if (gap < prop_band) begin
      motor.drive = (prop[POS_W+1:POS_W] != 2'b00) ? DRIVE_MAX : prop[DRV_W-1:0];
    end else begin
      motor.drive = full_drive;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dual_motor_position_drive_unit.sv @@
// Top level of the dual motor position drive.
// Depends on dmpd_pkg, the three channel interfaces, dmpd_cfg_regs and dmpd_motor_drive.
`default_nettype none

// Takes one command per clock while the input is not stalled. A command is registered
// in the execute-stage register on transfer and executed from there, where it reads
// and updates the position state and, for a tick or a poll, loads the result register,
// from which the result is offered. Set-target and position-sample commands give no
// result. Input stalls only while the executing command has a result and the result
// register is still held by the sink. Drive results use the configuration in place
// when the tick executes.
module dual_motor_position_drive_unit #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dmpd_item_if.sink   in_ch,
  dmpd_result_if.source out_ch,
  dmpd_cfg_if.sink    cfg_ch
);
  import dmpd_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  cfg_t cfg;

  // Execute-stage command register.
  logic             s1_valid;
  op_t              s1_op;
  logic [IDX_W-1:0] s1_idx;
  logic [POS_W-1:0] s1_value;

  logic [POS_W-1:0] target   [NUM_CHANNELS];
  logic [POS_W-1:0] measured [NUM_CHANNELS];
  logic [1:0]       done;
  logic [CH_W-1:0]  sample_channel;
  logic [CH_W-1:0]  sample_channel_next;

  motor_out_t wing;
  motor_out_t neck;

  logic             s1_has_result;
  logic             out_free;
  logic             s1_go;
  logic [POS_W-1:0] polled;

  dmpd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dmpd_motor_drive u_wing (
    .target         (target[0]),
    .measured       (measured[0]),
    .done_in        (done[0]),
    .stop_band      (cfg.stop_band),
    .prop_band      (cfg.prop_band),
    .full_drive     (cfg.full_drive),
    .offset_forward (cfg.wing_offset_forward),
    .offset_reverse (cfg.wing_offset_reverse),
    .motor          (wing)
  );

  dmpd_motor_drive u_neck (
    .target         (target[1]),
    .measured       (measured[1]),
    .done_in        (done[1]),
    .stop_band      (cfg.stop_band),
    .prop_band      (cfg.prop_band),
    .full_drive     (cfg.full_drive),
    .offset_forward (cfg.neck_offset_forward),
    .offset_reverse (cfg.neck_offset_reverse),
    .motor          (neck)
  );

  assign s1_has_result = (s1_op == OP_TICK) || (s1_op == OP_POLL);
  assign out_free      = !out_ch.valid || out_ch.ready;
  assign s1_go         = s1_valid && (!s1_has_result || out_free);
  assign in_ch.ready   = !s1_valid || s1_go;

  // A poll of a channel that does not exist answers zero.
  always_comb begin
    polled = '0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (int'(s1_idx) == ch) begin
        polled = measured[ch];
      end
    end
  end

  assign sample_channel_next = (sample_channel == CH_W'(NUM_CHANNELS - 1)) ?
                               '0 : sample_channel + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op    <= op_t'(in_ch.operation);
      s1_idx   <= in_ch.motor_index;
      s1_value <= in_ch.value;
    end
  end

  // Position state, done marks and the round-robin sample pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        target[ch]   <= reset_target(ch);
        measured[ch] <= '0;
      end
      done           <= '0;
      sample_channel <= '0;
    end else if (s1_go) begin
      case (s1_op)
        OP_SET_TARGET: begin
          for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (int'(s1_idx) == ch) begin
              target[ch] <= s1_value;
            end
          end
          // Only the two DC motors carry a done mark.
          for (int m = 0; m < 2; m++) begin
            if (int'(s1_idx) == m) begin
              done[m] <= 1'b0;
            end
          end
        end
        OP_SAMPLE: begin
          for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (int'(sample_channel) == ch) begin
              measured[ch] <= s1_value;
            end
          end
          sample_channel <= sample_channel_next;
        end
        OP_TICK: begin
          done <= {neck.done, wing.done};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_free) begin
      out_ch.valid <= s1_go && s1_has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && s1_has_result) begin
      if (s1_op == OP_TICK) begin
        out_ch.result_kind     <= KIND_DRIVE;
        out_ch.wing_reverse    <= wing.reverse;
        out_ch.wing_drive      <= wing.drive;
        out_ch.wing_done       <= wing.done;
        out_ch.neck_reverse    <= neck.reverse;
        out_ch.neck_drive      <= neck.drive;
        out_ch.neck_done       <= neck.done;
        out_ch.polled_position <= '0;
      end else begin
        out_ch.result_kind     <= KIND_POLL;
        out_ch.wing_reverse    <= 1'b0;
        out_ch.wing_drive      <= '0;
        out_ch.wing_done       <= 1'b0;
        out_ch.neck_reverse    <= 1'b0;
        out_ch.neck_drive      <= '0;
        out_ch.neck_done       <= 1'b0;
        out_ch.polled_position <= polled;
      end
    end
  end

endmodule

`default_nettype wire
